>>> hw/rtl/mhpq_pkg.sv
// Shared types and codes for the max-heap priority queue.
`timescale 1ns / 1ps

package mhpq_pkg;

  localparam int KEY_W   = 32;
  localparam int TOTAL_W = 8;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [1:0]              status_t;
  typedef logic [TOTAL_W-1:0]      total_t;

  // Command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // Status codes
  localparam status_t STATUS_OK    = 2'd0;
  localparam status_t STATUS_FULL  = 2'd1;
  localparam status_t STATUS_EMPTY = 2'd2;

endpackage

>>> hw/rtl/mhpq_req_if.sv
// Request channel: command and key, valid/ready handshake.
`timescale 1ns / 1ps

interface mhpq_req_if import mhpq_pkg::*; ();
  logic valid;
  logic ready;
  logic cmd;
  key_t key_value;

  modport source (output valid, cmd, key_value, input ready);
  modport sink   (input valid, cmd, key_value, output ready);
endinterface

>>> hw/rtl/mhpq_rsp_if.sv
// Response channel: removed key, status and entry total, valid/ready handshake.
`timescale 1ns / 1ps

interface mhpq_rsp_if import mhpq_pkg::*; ();
  logic    valid;
  logic    ready;
  key_t    max_key;
  status_t status;
  total_t  entry_total;

  modport source (output valid, max_key, status, entry_total, input ready);
  modport sink   (input valid, max_key, status, entry_total, output ready);
endinterface

>>> hw/rtl/mhpq_ram.sv
// Generic RAM: one write port, two registered read ports.
`timescale 1ns / 1ps

module mhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  output logic [WIDTH-1:0]         rd_data_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

>>> hw/rtl/max_heap_priority_queue_core.sv
// Top level: binary max-heap held in a RAM, sifted one tree level per cycle.
//
//  channel | dir | payload                              | handshake
//  --------+-----+--------------------------------------+-------------
//  req     | in  | cmd, key_value                       | valid/ready
//  rsp     | out | max_key, status, entry_total         | valid/ready
//
// One item at a time. An insert sifts its key up and a remove sifts the
// last key down from the root, moving at most log2(HEAP_DEPTH) levels,
// with one RAM read and one write-back per level. A remove of the last
// key skips the sift, and refused items go straight to the response.
// Reset (rst, synchronous) empties the heap; RAM contents are not cleared.
// A waiting response does not block the next item; only its write-out waits.
`timescale 1ns / 1ps

module max_heap_priority_queue_core import mhpq_pkg::*; #(
  parameter int HEAP_DEPTH = 128
) (
  input  logic       clk,
  input  logic       rst,
  mhpq_req_if.sink   req,
  mhpq_rsp_if.source rsp
);

  localparam int CW = $clog2(HEAP_DEPTH + 1);  // entry count
  localparam int AW = $clog2(HEAP_DEPTH);      // RAM address
  localparam int SW = CW + 1;                  // slot index incl. child overflow

  typedef enum logic [2:0] {S_IDLE, S_UP, S_RM, S_DOWN, S_HOLD} state_t;

  state_t          state;
  logic [CW-1:0]   count;
  logic [CW-1:0]   pos;
  key_t            hole_key;
  key_t            res_key;
  status_t         res_status;
  logic            rsp_valid;
  key_t            out_key;
  status_t         out_status;
  total_t          out_total;

  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [KEY_W-1:0] wr_data;
  logic [AW-1:0]   rd_addr_a;
  logic [AW-1:0]   rd_addr_b;
  logic [KEY_W-1:0] rd_a;
  logic [KEY_W-1:0] rd_b;

  logic [CW-1:0]   count_inc;
  logic [CW-1:0]   parent;
  logic [CW-1:0]   grand;
  logic [SW-1:0]   left;
  logic [SW-1:0]   right;
  logic [SW-1:0]   best_slot;
  logic            l_ok;
  logic            r_ok;
  logic            take_l;
  logic            take_r;
  key_t            best_key;
  logic            up_move;
  logic            down_move;
  logic            accept;

  // Slot n (1-based) lives at RAM address n - 1
  function automatic logic [AW-1:0] slot_addr(input logic [SW-1:0] slot);
    logic [SW-1:0] a;
    a = slot - SW'(1);
    return a[AW-1:0];
  endfunction

  mhpq_ram #(
    .WIDTH(KEY_W),
    .DEPTH(HEAP_DEPTH)
  ) u_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_data_a (rd_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_b (rd_b)
  );

  assign accept          = req.valid && req.ready;
  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = rsp_valid;
  assign rsp.max_key     = out_key;
  assign rsp.status      = out_status;
  assign rsp.entry_total = out_total;

  // Tree navigation and compares
  always_comb begin
    count_inc = count + CW'(1);
    parent    = pos >> 1;
    grand     = parent >> 1;
    left      = {pos, 1'b0};
    right     = {pos, 1'b1};
    l_ok      = left <= {1'b0, count};
    r_ok      = right <= {1'b0, count};
    // sift-down: larger child must beat the hole key strictly
    take_l    = l_ok && ($signed(rd_a) > hole_key);
    best_key  = take_l ? $signed(rd_a) : hole_key;
    take_r    = r_ok && ($signed(rd_b) > best_key);
    best_slot = take_r ? right : (take_l ? left : {1'b0, pos});
    down_move = take_l || take_r;
    // sift-up: key climbs while strictly above its parent
    up_move   = (pos != CW'(1)) && (hole_key > $signed(rd_a));
  end

  // RAM port drive
  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = slot_addr({1'b0, pos});
    wr_data   = hole_key;
    rd_addr_a = '0;
    rd_addr_b = '0;
    case (state)
      S_IDLE: begin
        if (req.cmd == CMD_INSERT) begin
          rd_addr_a = slot_addr({1'b0, count_inc >> 1});
        end else begin
          rd_addr_a = slot_addr(SW'(1));
          rd_addr_b = slot_addr({1'b0, count});
        end
      end
      S_UP: begin
        wr_en     = 1'b1;
        wr_data   = up_move ? rd_a : hole_key;
        rd_addr_a = slot_addr({1'b0, grand});
      end
      S_RM: begin
        rd_addr_a = slot_addr(SW'(2));
        rd_addr_b = slot_addr(SW'(3));
      end
      S_DOWN: begin
        wr_en     = 1'b1;
        wr_data   = down_move ? (take_r ? rd_b : best_key) : hole_key;
        rd_addr_a = slot_addr({best_slot[CW-1:0], 1'b0});
        rd_addr_b = slot_addr({best_slot[CW-1:0], 1'b1});
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Sequencer, count and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // a new response loaded in S_HOLD takes precedence over the clear
      if (rsp_valid && rsp.ready && state != S_HOLD) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            res_key <= '0;
            if (req.cmd == CMD_INSERT) begin
              if (count == CW'(HEAP_DEPTH)) begin
                res_status <= STATUS_FULL;
                state      <= S_HOLD;
              end else begin
                res_status <= STATUS_OK;
                count      <= count_inc;
                pos        <= count_inc;
                hole_key   <= req.key_value;
                state      <= S_UP;
              end
            end else begin
              if (count == '0) begin
                res_status <= STATUS_EMPTY;
                state      <= S_HOLD;
              end else begin
                res_status <= STATUS_OK;
                state      <= S_RM;
              end
            end
          end
        end
        S_UP: begin
          if (up_move) begin
            pos <= parent;
          end else begin
            state <= S_HOLD;
          end
        end
        S_RM: begin
          // root leaves, last entry becomes the hole key at the root
          res_key  <= $signed(rd_a);
          hole_key <= $signed(rd_b);
          count    <= count - CW'(1);
          pos      <= CW'(1);
          state    <= (count == CW'(1)) ? S_HOLD : S_DOWN;
        end
        S_DOWN: begin
          if (down_move) begin
            pos <= best_slot[CW-1:0];
          end else begin
            state <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid  <= 1'b1;
            out_key    <= res_key;
            out_status <= res_status;
            out_total  <= TOTAL_W'(count);
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(HEAP_DEPTH))
    else $error("entry count beyond heap depth");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_HOLD || state == S_RM) |-> !wr_en)
    else $error("RAM written outside a sift step");

  a_full_refused: assert property (@(posedge clk) disable iff (rst)
    (accept && req.cmd == CMD_INSERT && count == CW'(HEAP_DEPTH))
    |=> (state == S_HOLD && res_status == STATUS_FULL && $stable(count)))
    else $error("insert into full heap not refused");

  a_down_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DOWN) |-> (pos != '0 && pos <= count))
    else $error("sift-down position outside the heap");

endmodule

>>> tb/tb_max_heap_priority_queue_core.sv
// Self-checking testbench for the max-heap priority queue core.
`timescale 1ns / 1ps

module tb_max_heap_priority_queue_core;
  import mhpq_pkg::*;

  localparam int HEAP_DEPTH  = 128;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 2000;
  localparam int PRINT_CAP = 100;

  // One request item as queued for the driver, with its lead-in gap
  typedef struct {
    logic        cmd;
    key_t        key;
    int unsigned gap;
  } heap_req_t;

  // Expected response fields
  typedef struct {
    key_t    max_key;
    status_t status;
    total_t  entry_total;
  } heap_outcome_t;

  logic clk;
  logic rst;

  mhpq_req_if req_ch ();
  mhpq_rsp_if rsp_ch ();

  max_heap_priority_queue_core #(
    .HEAP_DEPTH(HEAP_DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Shadow heap used to predict responses
  key_t heap_model [1:HEAP_DEPTH];
  int unsigned model_count;

  heap_req_t     req_items[$];
  heap_outcome_t pending_outcomes[$];
  heap_outcome_t mon_want;
  heap_req_t     cur_item;

  logic        have_item;
  int unsigned send_wait;
  logic        req_hs;
  logic        rsp_hs;
  int unsigned rsp_wait;
  int unsigned hold_left;
  int unsigned holds_done;
  int unsigned req_accept_count;
  int unsigned rsp_count;
  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned gen_count;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_CAP) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    mismatch_count++;
  endtask

  // Apply one item to the shadow heap and return the response it must produce
  function automatic heap_outcome_t predict_outcome(input logic cmd, input key_t key);
    heap_outcome_t res;
    int unsigned pos;
    int unsigned parent;
    int unsigned l;
    int unsigned r;
    int unsigned best;
    key_t tmp;
    logic done;
    res.max_key = '0;
    res.status  = STATUS_OK;
    if (cmd == CMD_INSERT) begin
      if (model_count >= HEAP_DEPTH) begin
        res.status = STATUS_FULL;
      end else begin
        model_count++;
        heap_model[model_count] = key;
        // sift up while strictly greater than the parent
        pos = model_count;
        done = 1'b0;
        while (pos > 1 && !done) begin
          parent = pos / 2;
          if (heap_model[pos] > heap_model[parent]) begin
            tmp = heap_model[pos];
            heap_model[pos] = heap_model[parent];
            heap_model[parent] = tmp;
            pos = parent;
          end else begin
            done = 1'b1;
          end
        end
      end
    end else begin
      if (model_count == 0) begin
        res.status = STATUS_EMPTY;
      end else begin
        res.max_key = heap_model[1];
        heap_model[1] = heap_model[model_count];
        model_count--;
        // sift down toward the larger child
        pos = 1;
        done = (model_count == 0);
        while (!done) begin
          l = 2 * pos;
          r = l + 1;
          best = pos;
          if (l <= model_count && heap_model[l] > heap_model[best]) best = l;
          if (r <= model_count && heap_model[r] > heap_model[best]) best = r;
          if (best == pos) begin
            done = 1'b1;
          end else begin
            tmp = heap_model[pos];
            heap_model[pos] = heap_model[best];
            heap_model[best] = tmp;
            pos = best;
          end
        end
      end
    end
    res.entry_total = total_t'(model_count);
    return res;
  endfunction

  // Keys: extremes, a narrow band for ties, or fully random
  function automatic key_t pick_key();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: return key_t'(32'h7FFF_FFFF);
      1: return key_t'(32'h8000_0000);
      2, 3: return key_t'(int'($urandom_range(0, 8)) - 4);
      default: return key_t'($urandom);
    endcase
  endfunction

  task automatic add_item(input logic cmd, input key_t key, input logic burst);
    heap_req_t it;
    it.cmd = cmd;
    it.key = key;
    it.gap = burst ? 0 : $urandom_range(0, 10);
    req_items.push_back(it);
    if (cmd == CMD_INSERT && gen_count < HEAP_DEPTH) gen_count++;
    if (cmd == CMD_REMOVE && gen_count > 0) gen_count--;
  endtask

  // Request driver: holds each item until taken, then waits out the next gap
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid     <= 1'b0;
      req_ch.cmd       <= CMD_INSERT;
      req_ch.key_value <= '0;
      have_item = 1'b0;
      send_wait = 0;
    end else if (!req_ch.valid || req_hs) begin
      if (req_ch.valid) have_item = 1'b0;
      if (!have_item && req_items.size() != 0) begin
        cur_item = req_items.pop_front();
        have_item = 1'b1;
        send_wait = cur_item.gap;
      end
      if (have_item && send_wait == 0) begin
        req_ch.valid     <= 1'b1;
        req_ch.cmd       <= cur_item.cmd;
        req_ch.key_value <= cur_item.key;
      end else begin
        req_ch.valid <= 1'b0;
        if (have_item) send_wait--;
      end
    end
  end

  // Long receiver hold-offs so the core backs up and stalls its input
  always @(negedge clk) begin
    if (rst) begin
      hold_left  <= 0;
      holds_done <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if ((holds_done == 0 && req_accept_count >= 300) ||
                 (holds_done == 1 && req_accept_count >= 1300)) begin
      hold_left  <= 400;
      holds_done <= holds_done + 1;
    end
  end

  // Response receiver: random stall after each item, calm stretches in between
  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      rsp_wait = 0;
    end else begin
      if (rsp_hs) begin
        rsp_wait = ((rsp_count / 128) % 3 == 0) ? 0 : $urandom_range(0, 10);
      end else if (rsp_wait != 0 && hold_left == 0) begin
        rsp_wait--;
      end
      rsp_ch.ready <= (rsp_wait == 0) && (hold_left == 0);
    end
  end

  // Monitor: check responses against the oldest expectation, predict new items
  always @(posedge clk) begin
    if (rst) begin
      req_hs = 1'b0;
      rsp_hs = 1'b0;
    end else begin
      rsp_hs = rsp_ch.valid && rsp_ch.ready;
      req_hs = req_ch.valid && req_ch.ready;
      if (rsp_hs) begin
        rsp_count++;
        if (pending_outcomes.size() == 0) begin
          report_mismatch($sformatf("response %0d with no item outstanding", rsp_count));
        end else begin
          mon_want = pending_outcomes.pop_front();
          if (rsp_ch.max_key !== mon_want.max_key)
            report_mismatch($sformatf("response %0d max_key got %0d expected %0d",
                                      rsp_count, rsp_ch.max_key, mon_want.max_key));
          if (rsp_ch.status !== mon_want.status)
            report_mismatch($sformatf("response %0d status got %0d expected %0d",
                                      rsp_count, rsp_ch.status, mon_want.status));
          if (rsp_ch.entry_total !== mon_want.entry_total)
            report_mismatch($sformatf("response %0d entry_total got %0d expected %0d",
                                      rsp_count, rsp_ch.entry_total,
                                      mon_want.entry_total));
        end
      end
      if (req_hs) begin
        req_accept_count++;
        pending_outcomes.push_back(predict_outcome(req_ch.cmd, req_ch.key_value));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Stimulus and end of run
  initial begin
    int unsigned seg_no;
    int unsigned seg;
    int unsigned n;
    int unsigned ins_pct;
    int unsigned target;
    logic burst;
    rst = 1'b1;

    // Directed: remove on empty, extremes and duplicates, drain, remove on empty again
    add_item(CMD_REMOVE, pick_key(), 1'b0);
    add_item(CMD_INSERT, key_t'(0), 1'b0);
    add_item(CMD_INSERT, key_t'(32'h7FFF_FFFF), 1'b0);
    add_item(CMD_INSERT, key_t'(32'h8000_0000), 1'b0);
    add_item(CMD_INSERT, key_t'(-1), 1'b0);
    add_item(CMD_INSERT, key_t'(1), 1'b0);
    add_item(CMD_INSERT, key_t'(32'h7FFF_FFFF), 1'b0);
    add_item(CMD_INSERT, key_t'(32'h8000_0000), 1'b0);
    add_item(CMD_INSERT, key_t'(5), 1'b0);
    add_item(CMD_INSERT, key_t'(5), 1'b0);
    repeat (9) add_item(CMD_REMOVE, pick_key(), 1'b0);
    add_item(CMD_REMOVE, key_t'(32'hFFFF_FFFF), 1'b0);

    // Random: fill-to-full and drain-to-empty runs, mixed traffic, tie-heavy traffic
    target = req_items.size() + RANDOM_ITEMS;
    seg_no = 0;
    while (req_items.size() < target) begin
      burst = ($urandom_range(0, 3) == 0);
      if (seg_no == 0) seg = 0;
      else if (seg_no == 1) seg = 1;
      else seg = $urandom_range(0, 9);
      case (seg)
        0: begin
          while (gen_count < HEAP_DEPTH) add_item(CMD_INSERT, pick_key(), burst);
          repeat ($urandom_range(1, 3)) add_item(CMD_INSERT, pick_key(), burst);
        end
        1: begin
          while (gen_count > 0) add_item(CMD_REMOVE, pick_key(), burst);
          repeat ($urandom_range(1, 3)) add_item(CMD_REMOVE, pick_key(), burst);
        end
        2, 3: begin
          n = $urandom_range(10, 60);
          repeat (n) begin
            add_item(($urandom_range(0, 1) == 0) ? CMD_INSERT : CMD_REMOVE,
                     key_t'(int'($urandom_range(0, 6)) - 3), burst);
          end
        end
        default: begin
          n = $urandom_range(10, 80);
          ins_pct = $urandom_range(20, 80);
          repeat (n) begin
            add_item(($urandom_range(1, 100) <= ins_pct) ? CMD_INSERT : CMD_REMOVE,
                     pick_key(), burst);
          end
        end
      endcase
      seg_no++;
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Wait for every item to be taken and answered, then a short tail
    while (req_items.size() != 0 || have_item || req_ch.valid ||
           pending_outcomes.size() != 0) begin
      @(negedge clk);
    end
    repeat (20) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/mhpq_pkg.sv
hw/rtl/mhpq_req_if.sv
hw/rtl/mhpq_rsp_if.sv
hw/rtl/mhpq_ram.sv
hw/rtl/max_heap_priority_queue_core.sv
tb/tb_max_heap_priority_queue_core.sv
